FILE: src/ctt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_pkg
// shared types, codes and sizes of the config text tokenizer
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int LINE_BITS_DEF   = 24;
  localparam int COLUMN_BITS_DEF = 16;

  // results one byte can cause, and depth of the result queue
  localparam int MAX_RES     = 4;
  localparam int QUEUE_DEPTH = 8;

  localparam logic [3:0] KIND_TEXT    = 4'd0;
  localparam logic [3:0] KIND_TERM    = 4'd1;
  localparam logic [3:0] KIND_LBRACE  = 4'd2;
  localparam logic [3:0] KIND_RBRACE  = 4'd3;
  localparam logic [3:0] KIND_LBRACK  = 4'd4;
  localparam logic [3:0] KIND_RBRACK  = 4'd5;
  localparam logic [3:0] KIND_EQUAL   = 4'd6;
  localparam logic [3:0] KIND_COMMA   = 4'd7;
  localparam logic [3:0] KIND_STR_END = 4'd8;
  localparam logic [3:0] KIND_NUMBER  = 4'd9;
  localparam logic [3:0] KIND_BOOL    = 4'd10;
  localparam logic [3:0] KIND_ID_END  = 4'd11;
  localparam logic [3:0] KIND_EOF     = 4'd12;
  localparam logic [3:0] KIND_ERROR   = 4'd13;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NO_DIGITS  = 3'd1;
  localparam logic [2:0] ERR_FLOAT      = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd3;
  localparam logic [2:0] ERR_UNTERM     = 3'd4;
  localparam logic [2:0] ERR_BAD_ESCAPE = 3'd5;
  localparam logic [2:0] ERR_BAD_UTF8   = 3'd6;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd7;

  localparam logic [2:0] NF_NEG   = 3'b001;
  localparam logic [2:0] NF_OVF   = 3'b010;
  localparam logic [2:0] NF_DIGIT = 3'b100;

  typedef enum logic [2:0] {
    MODE_BETWEEN, MODE_COMMENT, MODE_IDENT, MODE_NUMBER,
    MODE_STRING, MODE_ESCAPE, MODE_UTF8
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [63:0] magnitude;
    logic [2:0]  flags;
    logic [4:0]  kw;
    logic [2:0]  want;
    logic [2:0]  held;
  } lex_state_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  text_byte;
    logic [63:0] number_value;
    logic [2:0]  error_code;
    logic [31:0] start_offset;
    logic [23:0] start_line;
    logic [15:0] start_column;
    logic [31:0] token_length;
    logic        last;
  } result_t;

endpackage

FILE: src/ctt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_in_if
// byte channel into the tokenizer
// ----------------------------------------------------------------------------
interface ctt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       at_end;

  modport source(output valid, in_byte, at_end, input ready);
  modport sink(input valid, in_byte, at_end, output ready);
endinterface

FILE: src/ctt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_out_if
// token event channel out of the tokenizer
// ----------------------------------------------------------------------------
interface ctt_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic [7:0]         text_byte;
  logic signed [63:0] number_value;
  logic [2:0]         error_code;
  logic [31:0]        start_offset;
  logic [23:0]        start_line;
  logic [15:0]        start_column;
  logic [31:0]        token_length;
  logic               last;

  modport source(output valid, kind, text_byte, number_value, error_code, start_offset,
                 start_line, start_column, token_length, last, input ready);
  modport sink(input valid, kind, text_byte, number_value, error_code, start_offset,
               start_line, start_column, token_length, last, output ready);
endinterface

FILE: src/config_text_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_text_tokenizer_core
// streaming tokenizer for configuration text, one byte per transaction
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                          | handshake
//  ---------+-----+--------------------------------------------------+----------
//  in_ch    | in  | in_byte, at_end                                  | valid/ready
//  out_ch   | out | kind, text_byte, number_value, error_code,       | valid/ready
//           |     | start_offset/line/column, token_length, last     |
//
//  one byte per cycle while in_ch.ready is high: the lexer step is
//  combinational from the state registers to an 8-entry result queue,
//  and one event leaves per cycle while out_ch.ready is high
//  in_ch.ready is high while the queue has room for a full burst of four
//  events, so input stalls only when the output side falls behind
//  synchronous reset returns the lexer to between tokens at offset 0,
//  line 1, column 1 and empties the queue
module config_text_tokenizer_core #(
  parameter int OFFSET_BITS = ctt_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = ctt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = ctt_pkg::COLUMN_BITS_DEF
) (
  input logic clk,
  input logic rst,
  ctt_in_if.sink    in_ch,
  ctt_out_if.source out_ch
);
  import ctt_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);

  // lexer state and source position
  lex_state_t             st;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [LINE_BITS-1:0]   line_count;
  logic [COLUMN_BITS-1:0] column_count;
  logic [OFFSET_BITS-1:0] tok_offset;
  logic [LINE_BITS-1:0]   tok_line;
  logic [COLUMN_BITS-1:0] tok_column;
  logic [OFFSET_BITS-1:0] escape_offset;
  logic [LINE_BITS-1:0]   escape_line;
  logic [COLUMN_BITS-1:0] escape_column;
  logic [7:0]             utf8_buffer [4];

  lex_state_t             st_next;
  logic [OFFSET_BITS-1:0] byte_offset_next;
  logic [LINE_BITS-1:0]   line_count_next;
  logic [COLUMN_BITS-1:0] column_count_next;
  logic [OFFSET_BITS-1:0] tok_offset_next;
  logic [LINE_BITS-1:0]   tok_line_next;
  logic [COLUMN_BITS-1:0] tok_column_next;
  logic [OFFSET_BITS-1:0] escape_offset_next;
  logic [LINE_BITS-1:0]   escape_line_next;
  logic [COLUMN_BITS-1:0] escape_column_next;
  logic [7:0]             utf8_buffer_next [4];
  logic [2:0]             nres;
  result_t                res [4];

  // result queue
  result_t       queue [QUEUE_DEPTH];
  logic [QW-1:0] head;
  logic [QW-1:0] tail;
  logic [QW:0]   count;

  logic          in_fire;
  logic          out_fire;
  logic [2:0]    push_n;

  ctt_step #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_step (
    .in_byte  (in_ch.in_byte),
    .at_end   (in_ch.at_end),
    .st       (st),
    .bo       (byte_offset),
    .ln       (line_count),
    .cl       (column_count),
    .to       (tok_offset),
    .tl       (tok_line),
    .tc       (tok_column),
    .eo       (escape_offset),
    .el       (escape_line),
    .ec       (escape_column),
    .sbuf     (utf8_buffer),
    .st_next  (st_next),
    .bo_next  (byte_offset_next),
    .ln_next  (line_count_next),
    .cl_next  (column_count_next),
    .to_next  (tok_offset_next),
    .tl_next  (tok_line_next),
    .tc_next  (tok_column_next),
    .eo_next  (escape_offset_next),
    .el_next  (escape_line_next),
    .ec_next  (escape_column_next),
    .sbuf_next(utf8_buffer_next),
    .nres     (nres),
    .res      (res)
  );

  // room for a full burst keeps the queue from ever overflowing
  assign in_ch.ready = count <= (QW+1)'(QUEUE_DEPTH - MAX_RES);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign push_n      = in_fire ? nres : 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= '{mode: MODE_BETWEEN, magnitude: '0, flags: '0, kw: '0,
                         want: '0, held: '0};
      byte_offset   <= '0;
      line_count    <= LINE_BITS'(1);
      column_count  <= COLUMN_BITS'(1);
      tok_offset    <= '0;
      tok_line      <= LINE_BITS'(1);
      tok_column    <= COLUMN_BITS'(1);
      escape_offset <= '0;
      escape_line   <= LINE_BITS'(1);
      escape_column <= COLUMN_BITS'(1);
    end else if (in_fire) begin
      st            <= st_next;
      byte_offset   <= byte_offset_next;
      line_count    <= line_count_next;
      column_count  <= column_count_next;
      tok_offset    <= tok_offset_next;
      tok_line      <= tok_line_next;
      tok_column    <= tok_column_next;
      escape_offset <= escape_offset_next;
      escape_line   <= escape_line_next;
      escape_column <= escape_column_next;
    end
  end

  // utf-8 holding bytes are always written before they are read
  always_ff @(posedge clk) begin
    if (in_fire) utf8_buffer <= utf8_buffer_next;
  end

  // burst write of up to four events at the tail
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (in_fire && 3'(k) < nres) queue[tail + QW'(k)] <= res[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + QW'(push_n);
      if (out_fire) head <= head + 1'b1;
      count <= count + (QW+1)'(push_n) - (QW+1)'(out_fire);
    end
  end

  // event at the head of the queue
  assign out_ch.valid        = count != '0;
  assign out_ch.kind         = queue[head].kind;
  assign out_ch.text_byte    = queue[head].text_byte;
  assign out_ch.number_value = $signed(queue[head].number_value);
  assign out_ch.error_code   = queue[head].error_code;
  assign out_ch.start_offset = queue[head].start_offset;
  assign out_ch.start_line   = queue[head].start_line;
  assign out_ch.start_column = queue[head].start_column;
  assign out_ch.token_length = queue[head].token_length;
  assign out_ch.last         = queue[head].last;

endmodule

FILE: src/ctt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_step
// lexer next state and the token events caused by one byte
// ----------------------------------------------------------------------------
module ctt_step #(
  parameter int OFFSET_BITS = ctt_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = ctt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = ctt_pkg::COLUMN_BITS_DEF
) (
  input  logic [7:0]             in_byte,
  input  logic                   at_end,
  input  ctt_pkg::lex_state_t    st,
  input  logic [OFFSET_BITS-1:0] bo,
  input  logic [LINE_BITS-1:0]   ln,
  input  logic [COLUMN_BITS-1:0] cl,
  input  logic [OFFSET_BITS-1:0] to,
  input  logic [LINE_BITS-1:0]   tl,
  input  logic [COLUMN_BITS-1:0] tc,
  input  logic [OFFSET_BITS-1:0] eo,
  input  logic [LINE_BITS-1:0]   el,
  input  logic [COLUMN_BITS-1:0] ec,
  input  logic [7:0]             sbuf [4],
  output ctt_pkg::lex_state_t    st_next,
  output logic [OFFSET_BITS-1:0] bo_next,
  output logic [LINE_BITS-1:0]   ln_next,
  output logic [COLUMN_BITS-1:0] cl_next,
  output logic [OFFSET_BITS-1:0] to_next,
  output logic [LINE_BITS-1:0]   tl_next,
  output logic [COLUMN_BITS-1:0] tc_next,
  output logic [OFFSET_BITS-1:0] eo_next,
  output logic [LINE_BITS-1:0]   el_next,
  output logic [COLUMN_BITS-1:0] ec_next,
  output logic [7:0]             sbuf_next [4],
  output logic [2:0]             nres,
  output ctt_pkg::result_t       res [4]
);
  import ctt_pkg::*;

  function automatic result_t mk(logic [3:0] k, logic [7:0] t, logic [63:0] v, logic [2:0] e,
                                 logic [OFFSET_BITS-1:0] o, logic [LINE_BITS-1:0] l,
                                 logic [COLUMN_BITS-1:0] c, logic [OFFSET_BITS-1:0] len);
    result_t     r;
    logic [63:0] wo;
    logic [63:0] wl;
    logic [31:0] wln;
    logic [31:0] wc;
    wo  = 64'(o);
    wl  = 64'(len);
    wln = 32'(l);
    wc  = 32'(c);
    r.kind         = k;
    r.text_byte    = t;
    r.number_value = v;
    r.error_code   = e;
    r.start_offset = wo[31:0];
    r.start_line   = wln[23:0];
    r.start_column = wc[15:0];
    r.token_length = wl[31:0];
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [2:0] seq_want(logic [7:0] b);
    if (b[7:5] == 3'b110) return 3'd2;
    if (b[7:4] == 4'b1110) return 3'd3;
    if (b[7:3] == 5'b11110) return 3'd4;
    return 3'd1;
  endfunction

  function automatic logic [4:0] kw_step(logic [4:0] t, logic [7:0] b);
    logic [7:0] w;
    case (t)
      5'd1: w = "r";
      5'd2: w = "u";
      5'd3: w = "e";
      5'd5: w = "a";
      5'd6: w = "l";
      5'd7: w = "s";
      5'd8: w = "e";
      default: w = 8'h00;
    endcase
    return (w != 8'h00 && b == w) ? t + 5'd1 : 5'd0;
  endfunction

  function automatic logic seq_ok(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                  logic [7:0] b3, logic [2:0] w);
    logic c1;
    logic c2;
    logic c3;
    logic ok;
    c1 = b1 >= 8'h80 && b1 <= 8'hbf;
    c2 = b2 >= 8'h80 && b2 <= 8'hbf;
    c3 = b3 >= 8'h80 && b3 <= 8'hbf;
    case (w)
      3'd1: ok = b0 < 8'h80;
      3'd2: ok = c1 && b0 >= 8'hc2 && b0 <= 8'hdf;
      3'd3: begin
        if (b0 == 8'he0) ok = b1 >= 8'ha0;
        else if (b0 == 8'hed) ok = b1 <= 8'h9f;
        else ok = b0 >= 8'he1 && b0 <= 8'hef;
        ok = ok && c1 && c2;
      end
      3'd4: begin
        if (b0 == 8'hf0) ok = b1 >= 8'h90;
        else if (b0 == 8'hf4) ok = b1 <= 8'h8f;
        else ok = b0 >= 8'hf1 && b0 <= 8'hf3;
        ok = ok && c1 && c2 && c3;
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // saturating position after the current byte
  logic [OFFSET_BITS-1:0] abo;
  logic [LINE_BITS-1:0]   aln;
  logic [COLUMN_BITS-1:0] acl;
  always_comb begin
    abo = (bo != '1) ? bo + 1'b1 : bo;
    if (in_byte == "\n") begin
      aln = (ln != '1) ? ln + 1'b1 : ln;
      acl = COLUMN_BITS'(1);
    end else begin
      aln = ln;
      acl = (cl != '1) ? cl + 1'b1 : cl;
    end
  end

  // digit accumulate on the held magnitude: overflow when 10*m + d exceeds the limit
  logic [67:0] acc;
  logic [63:0] limit;
  logic        acc_ovf;
  always_comb begin
    acc     = {st.magnitude, 3'b000} + {3'b000, st.magnitude, 1'b0} + 68'(in_byte - "0");
    limit   = st.flags[0] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    acc_ovf = acc > {4'h0, limit};
  end

  // closing events of identifiers and numbers, seen from the held state
  result_t close_id;
  result_t close_num;
  logic    dot_next;
  always_comb begin
    dot_next = !at_end && in_byte == ".";
    if (st.kw == 5'd4)
      close_id = mk(KIND_BOOL, 8'h00, 64'd1, ERR_NONE, to, tl, tc, bo - to);
    else if (st.kw == 5'd9)
      close_id = mk(KIND_BOOL, 8'h00, 64'd0, ERR_NONE, to, tl, tc, bo - to);
    else
      close_id = mk(KIND_ID_END, 8'h00, 64'd0, ERR_NONE, to, tl, tc, bo - to);
    if ((st.flags & NF_DIGIT) == 3'b000)
      close_num = mk(KIND_ERROR, 8'h00, 64'd0, ERR_NO_DIGITS, to, tl, tc, bo - to);
    else if (dot_next)
      close_num = mk(KIND_ERROR, 8'h00, 64'd0, ERR_FLOAT, to, tl, tc, bo - to);
    else if ((st.flags & NF_OVF) != 3'b000)
      close_num = mk(KIND_ERROR, 8'h00, 64'd0, ERR_OVERFLOW, to, tl, tc, bo - to);
    else if (st.flags[0] && st.magnitude != 64'd0)
      close_num = mk(KIND_NUMBER, 8'h00, 64'd0 - st.magnitude, ERR_NONE, to, tl, tc, bo - to);
    else
      close_num = mk(KIND_NUMBER, 8'h00, st.magnitude, ERR_NONE, to, tl, tc, bo - to);
  end

  lex_state_t s;
  logic       go_between;
  logic       is_p;
  logic [3:0] pk;
  logic [7:0] dec;
  logic       fin;

  always_comb begin
    s          = st;
    bo_next    = bo;
    ln_next    = ln;
    cl_next    = cl;
    to_next    = to;
    tl_next    = tl;
    tc_next    = tc;
    eo_next    = eo;
    el_next    = el;
    ec_next    = ec;
    sbuf_next  = sbuf;
    nres       = 3'd0;
    res        = '{default: '0};
    go_between = 1'b0;
    is_p       = 1'b0;
    pk         = KIND_TERM;
    dec        = in_byte;
    fin        = 1'b0;
    if (at_end) begin
      case (st.mode)
        MODE_IDENT: begin
          res[0] = close_id;
          nres   = 3'd1;
          s.kw   = 5'd0;
        end
        MODE_NUMBER: begin
          res[0] = close_num;
          nres   = 3'd1;
        end
        MODE_STRING, MODE_ESCAPE, MODE_UTF8: begin
          res[0] = mk(KIND_ERROR, 8'h00, 64'd0, ERR_UNTERM, to, tl, tc, bo - to);
          nres   = 3'd1;
        end
        default: ;
      endcase
      s.mode = MODE_BETWEEN;
      s.want = 3'd0;
      s.held = 3'd0;
      res[nres[1:0]] = mk(KIND_EOF, 8'h00, 64'd0, ERR_NONE, bo, ln, cl, '0);
      nres = nres + 3'd1;
    end else begin
      case (st.mode)
        MODE_COMMENT: begin
          if (in_byte != "\n") begin
            bo_next = abo;
            ln_next = aln;
            cl_next = acl;
          end else begin
            go_between = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == "-" || in_byte == ".") begin
            res[0]  = mk(KIND_TEXT, in_byte, 64'd0, ERR_NONE, to, tl, tc, '0);
            nres    = 3'd1;
            s.kw    = kw_step(st.kw, in_byte);
            bo_next = abo;
            ln_next = aln;
            cl_next = acl;
          end else begin
            res[0]     = close_id;
            nres       = 3'd1;
            s.kw       = 5'd0;
            go_between = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(in_byte)) begin
            s.flags = st.flags | NF_DIGIT | (acc_ovf ? NF_OVF : 3'b000);
            if (!(st.flags[1] || acc_ovf)) s.magnitude = acc[63:0];
            bo_next = abo;
            ln_next = aln;
            cl_next = acl;
          end else begin
            res[0]     = close_num;
            nres       = 3'd1;
            go_between = 1'b1;
          end
        end
        MODE_STRING: begin
          bo_next = abo;
          ln_next = aln;
          cl_next = acl;
          if (in_byte == "\"") begin
            res[0] = mk(KIND_STR_END, 8'h00, 64'd0, ERR_NONE, to, tl, tc, abo - to);
            nres   = 3'd1;
            s.mode = MODE_BETWEEN;
          end else if (in_byte == "\\") begin
            eo_next = abo;
            el_next = aln;
            ec_next = acl;
            s.mode  = MODE_ESCAPE;
          end else begin
            sbuf_next[0] = in_byte;
            s.want       = seq_want(in_byte);
            s.held       = 3'd1;
            if (s.want == 3'd1) fin = 1'b1;
            else s.mode = MODE_UTF8;
          end
        end
        MODE_ESCAPE: begin
          bo_next = abo;
          ln_next = aln;
          cl_next = acl;
          if (in_byte == "\"" || in_byte == "\\" || in_byte == "n" || in_byte == "t") begin
            if (in_byte == "n") dec = "\n";
            else if (in_byte == "t") dec = "\t";
            res[0] = mk(KIND_TEXT, dec, 64'd0, ERR_NONE, to, tl, tc, '0);
            nres   = 3'd1;
            s.mode = MODE_STRING;
          end else begin
            res[0] = mk(KIND_ERROR, 8'h00, 64'd0, ERR_BAD_ESCAPE, eo, el, ec,
                        OFFSET_BITS'(1));
            nres   = 3'd1;
            s.mode = MODE_BETWEEN;
          end
        end
        MODE_UTF8: begin
          sbuf_next[st.held[1:0]] = in_byte;
          s.held  = st.held + 3'd1;
          bo_next = abo;
          ln_next = aln;
          cl_next = acl;
          if (s.held >= s.want) fin = 1'b1;
        end
        default: go_between = 1'b1;
      endcase

      // a complete utf-8 sequence goes out whole, or as one error
      if (fin) begin
        if (s.want >= 3'd1 && s.want <= 3'd4 &&
            seq_ok(sbuf_next[0], sbuf_next[1], sbuf_next[2], sbuf_next[3], s.want)) begin
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < s.want)
              res[i] = mk(KIND_TEXT, sbuf_next[i], 64'd0, ERR_NONE, to, tl, tc, '0);
          end
          nres   = s.want;
          s.mode = MODE_STRING;
        end else begin
          res[0] = mk(KIND_ERROR, 8'h00, 64'd0, ERR_BAD_UTF8, to, tl, tc, abo - to);
          nres   = 3'd1;
          s.mode = MODE_BETWEEN;
        end
        s.want = 3'd0;
        s.held = 3'd0;
      end

      if (go_between) begin
        s.mode = MODE_BETWEEN;
        case (in_byte)
          " ", "\t", "\r": begin
            bo_next = abo;
            ln_next = aln;
            cl_next = acl;
          end
          "#": begin
            s.mode  = MODE_COMMENT;
            bo_next = abo;
            ln_next = aln;
            cl_next = acl;
          end
          "\n", ";": is_p = 1'b1;
          "{": begin is_p = 1'b1; pk = KIND_LBRACE; end
          "}": begin is_p = 1'b1; pk = KIND_RBRACE; end
          "[": begin is_p = 1'b1; pk = KIND_LBRACK; end
          "]": begin is_p = 1'b1; pk = KIND_RBRACK; end
          "=": begin is_p = 1'b1; pk = KIND_EQUAL; end
          ",": begin is_p = 1'b1; pk = KIND_COMMA; end
          "\"": begin
            to_next = bo;
            tl_next = ln;
            tc_next = cl;
            bo_next = abo;
            ln_next = aln;
            cl_next = acl;
            s.mode  = MODE_STRING;
          end
          default: begin
            to_next = bo;
            tl_next = ln;
            tc_next = cl;
            bo_next = abo;
            ln_next = aln;
            cl_next = acl;
            if (in_byte == "-" || is_digit(in_byte)) begin
              s.magnitude = 64'd0;
              s.flags     = 3'b000;
              if (in_byte == "-") begin
                s.flags = NF_NEG;
              end else begin
                s.magnitude = 64'(in_byte - "0");
                s.flags     = NF_DIGIT;
              end
              s.mode = MODE_NUMBER;
            end else if (is_alpha(in_byte)) begin
              s.kw = (in_byte == "t") ? 5'd1 : (in_byte == "f") ? 5'd5 : 5'd0;
              res[nres[1:0]] = mk(KIND_TEXT, in_byte, 64'd0, ERR_NONE, bo, ln, cl, '0);
              nres   = nres + 3'd1;
              s.mode = MODE_IDENT;
            end else begin
              res[nres[1:0]] = mk(KIND_ERROR, 8'h00, 64'd0, ERR_UNEXPECTED, bo, ln, cl,
                                  abo - bo);
              nres = nres + 3'd1;
            end
          end
        endcase
        if (is_p) begin
          to_next = bo;
          tl_next = ln;
          tc_next = cl;
          bo_next = abo;
          ln_next = aln;
          cl_next = acl;
          res[nres[1:0]] = mk(pk, 8'h00, 64'd0, ERR_NONE, bo, ln, cl, abo - bo);
          nres = nres + 3'd1;
        end
      end
    end
    if (nres != 3'd0) res[nres[1:0] - 2'd1].last = 1'b1;
    st_next = s;
  end

endmodule

FILE: src/ctt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_checker
// port-level checks on the tokenizer event stream
// ----------------------------------------------------------------------------
module ctt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  kind,
  input logic [2:0]  error_code,
  input logic [31:0] token_length,
  input logic        last
);
  import ctt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("event dropped while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("event shown right after reset");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EOF |-> last)
    else $error("eof is not the final event of its byte");

  a_text_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_TEXT |-> token_length == 32'd0)
    else $error("text byte with nonzero length");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERROR |-> error_code != ERR_NONE)
    else $error("error event without a code");

endmodule

bind config_text_tokenizer_core ctt_checker u_ctt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .kind        (out_ch.kind),
  .error_code  (out_ch.error_code),
  .token_length(out_ch.token_length),
  .last        (out_ch.last)
);

FILE: tb/sv/ctt_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_token_checker
// watches both channels of the tokenizer, predicts the token events of each
// accepted byte and compares every event leaving the block field by field
// ----------------------------------------------------------------------------
module ctt_token_checker
  import ctt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ctt_in_if    in_ch,
  ctt_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  mode_t       mode;
  logic [31:0] pos_off;
  logic [23:0] pos_line;
  logic [15:0] pos_col;
  logic [31:0] tok_off;
  logic [23:0] tok_line;
  logic [15:0] tok_col;
  logic [31:0] esc_off;
  logic [23:0] esc_line;
  logic [15:0] esc_col;
  logic [63:0] mag;
  logic [2:0]  nflags;
  logic [4:0]  kw;
  logic [7:0]  ubuf [4];
  logic [2:0]  u_want;
  logic [2:0]  u_held;

  result_t step_events[$];
  result_t expected_events[$];

  assign pending = expected_events.size();

  function automatic void add_event(logic [3:0] k, logic [7:0] t, logic [63:0] v,
                                    logic [2:0] e, logic [31:0] o, logic [23:0] l,
                                    logic [15:0] c, logic [31:0] n);
    result_t r;
    if (step_events.size() >= MAX_RES) return;
    r = '{kind: k, text_byte: t, number_value: v, error_code: e, start_offset: o,
          start_line: l, start_column: c, token_length: n, last: 1'b0};
    step_events.push_back(r);
  endfunction

  function automatic void tok_event(logic [3:0] k, logic [7:0] t, logic [63:0] v,
                                    logic [2:0] e, bit with_len);
    add_event(k, t, v, e, tok_off, tok_line, tok_col, with_len ? pos_off - tok_off : 32'd0);
  endfunction

  function automatic void mark_start();
    tok_off = pos_off;
    tok_line = pos_line;
    tok_col = pos_col;
  endfunction

  function automatic void advance(logic [7:0] b);
    if (pos_off != '1) pos_off++;
    if (b == 8'h0a) begin
      if (pos_line != '1) pos_line++;
      pos_col = 16'd1;
    end else if (pos_col != '1) begin
      pos_col++;
    end
  endfunction

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [2:0] lead_length(logic [7:0] b);
    if (b[7:5] == 3'b110) return 3'd2;
    if (b[7:4] == 4'b1110) return 3'd3;
    if (b[7:3] == 5'b11110) return 3'd4;
    return 3'd1;
  endfunction

  function automatic bit utf8_ok(logic [2:0] want);
    for (int i = 1; i < want; i++)
      if (ubuf[i] < 8'h80 || ubuf[i] > 8'hbf) return 0;
    case (want)
      3'd1: return ubuf[0] < 8'h80;
      3'd2: return ubuf[0] >= 8'hc2 && ubuf[0] <= 8'hdf;
      3'd3: begin
        if (ubuf[0] == 8'he0) return ubuf[1] >= 8'ha0;
        if (ubuf[0] == 8'hed) return ubuf[1] <= 8'h9f;
        return ubuf[0] >= 8'he1 && ubuf[0] <= 8'hef;
      end
      3'd4: begin
        if (ubuf[0] == 8'hf0) return ubuf[1] >= 8'h90;
        if (ubuf[0] == 8'hf4) return ubuf[1] <= 8'h8f;
        return ubuf[0] >= 8'hf1 && ubuf[0] <= 8'hf3;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void close_sequence();
    if (utf8_ok(u_want)) begin
      for (int i = 0; i < u_want; i++) tok_event(KIND_TEXT, ubuf[i], 64'd0, ERR_NONE, 0);
      mode = MODE_STRING;
    end else begin
      tok_event(KIND_ERROR, 8'd0, 64'd0, ERR_BAD_UTF8, 1);
      mode = MODE_BETWEEN;
    end
    u_want = 3'd0;
    u_held = 3'd0;
  endfunction

  function automatic void close_ident();
    if (kw == 5'd4) tok_event(KIND_BOOL, 8'd0, 64'd1, ERR_NONE, 1);
    else if (kw == 5'd9) tok_event(KIND_BOOL, 8'd0, 64'd0, ERR_NONE, 1);
    else tok_event(KIND_ID_END, 8'd0, 64'd0, ERR_NONE, 1);
    kw = 5'd0;
    mode = MODE_BETWEEN;
  endfunction

  function automatic void close_number(bit dot);
    if (!nflags[2]) tok_event(KIND_ERROR, 8'd0, 64'd0, ERR_NO_DIGITS, 1);
    else if (dot) tok_event(KIND_ERROR, 8'd0, 64'd0, ERR_FLOAT, 1);
    else if (nflags[1]) tok_event(KIND_ERROR, 8'd0, 64'd0, ERR_OVERFLOW, 1);
    else if (nflags[0]) tok_event(KIND_NUMBER, 8'd0, 64'd0 - mag, ERR_NONE, 1);
    else tok_event(KIND_NUMBER, 8'd0, mag, ERR_NONE, 1);
    mode = MODE_BETWEEN;
  endfunction

  function automatic void add_digit(logic [7:0] b);
    logic [63:0] d;
    logic [63:0] lim;
    d = 64'(b - "0");
    lim = nflags[0] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    nflags = nflags | NF_DIGIT;
    if (mag > (lim - d) / 10) nflags = nflags | NF_OVF;
    if (!nflags[1]) mag = mag * 10 + d;
  endfunction

  function automatic void keyword_next(logic [7:0] b);
    string tw;
    string fw;
    tw = "true";
    fw = "false";
    if (kw >= 1 && kw <= 3 && b == tw[kw]) kw++;
    else if (kw >= 5 && kw <= 8 && b == fw[kw - 4]) kw++;
    else kw = 5'd0;
  endfunction

  function automatic void punct(logic [3:0] k, logic [7:0] b);
    mark_start();
    advance(b);
    tok_event(k, 8'd0, 64'd0, ERR_NONE, 1);
  endfunction

  function automatic void lex_between(logic [7:0] b);
    case (b)
      " ", 8'h09, 8'h0d: begin advance(b); return; end
      "#": begin mode = MODE_COMMENT; advance(b); return; end
      8'h0a, ";": begin punct(KIND_TERM, b); return; end
      "{": begin punct(KIND_LBRACE, b); return; end
      "}": begin punct(KIND_RBRACE, b); return; end
      "[": begin punct(KIND_LBRACK, b); return; end
      "]": begin punct(KIND_RBRACK, b); return; end
      "=": begin punct(KIND_EQUAL, b); return; end
      ",": begin punct(KIND_COMMA, b); return; end
      8'h22: begin mark_start(); advance(b); mode = MODE_STRING; return; end
      default: ;
    endcase
    mark_start();
    if (b == "-" || is_digit(b)) begin
      mag = 64'd0;
      nflags = 3'd0;
      if (b == "-") nflags = NF_NEG;
      else add_digit(b);
      advance(b);
      mode = MODE_NUMBER;
    end else if (is_alpha(b)) begin
      kw = (b == "t") ? 5'd1 : (b == "f") ? 5'd5 : 5'd0;
      tok_event(KIND_TEXT, b, 64'd0, ERR_NONE, 0);
      advance(b);
      mode = MODE_IDENT;
    end else begin
      advance(b);
      tok_event(KIND_ERROR, 8'd0, 64'd0, ERR_UNEXPECTED, 1);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] b);
    case (mode)
      MODE_COMMENT: begin
        if (b != 8'h0a) begin advance(b); return; end
        mode = MODE_BETWEEN;
      end
      MODE_IDENT: begin
        if (is_alpha(b) || is_digit(b) || b == "-" || b == ".") begin
          tok_event(KIND_TEXT, b, 64'd0, ERR_NONE, 0);
          keyword_next(b);
          advance(b);
          return;
        end
        close_ident();
      end
      MODE_NUMBER: begin
        if (is_digit(b)) begin add_digit(b); advance(b); return; end
        close_number(b == ".");
      end
      MODE_STRING: begin
        advance(b);
        if (b == 8'h22) begin
          tok_event(KIND_STR_END, 8'd0, 64'd0, ERR_NONE, 1);
          mode = MODE_BETWEEN;
        end else if (b == 8'h5c) begin
          esc_off = pos_off;
          esc_line = pos_line;
          esc_col = pos_col;
          mode = MODE_ESCAPE;
        end else begin
          ubuf[0] = b;
          u_want = lead_length(b);
          u_held = 3'd1;
          if (u_want == 3'd1) close_sequence();
          else mode = MODE_UTF8;
        end
        return;
      end
      MODE_ESCAPE: begin
        advance(b);
        if (b == 8'h22 || b == 8'h5c || b == "n" || b == "t") begin
          tok_event(KIND_TEXT, b == "n" ? 8'h0a : b == "t" ? 8'h09 : b, 64'd0, ERR_NONE, 0);
          mode = MODE_STRING;
        end else begin
          add_event(KIND_ERROR, 8'd0, 64'd0, ERR_BAD_ESCAPE, esc_off, esc_line, esc_col, 32'd1);
          mode = MODE_BETWEEN;
        end
        return;
      end
      MODE_UTF8: begin
        ubuf[u_held[1:0]] = b;
        u_held++;
        advance(b);
        if (u_held >= u_want) close_sequence();
        return;
      end
      default: mode = MODE_BETWEEN;
    endcase
    lex_between(b);
  endfunction

  function automatic void lex_end();
    case (mode)
      MODE_IDENT: close_ident();
      MODE_NUMBER: close_number(0);
      MODE_STRING, MODE_ESCAPE, MODE_UTF8:
        tok_event(KIND_ERROR, 8'd0, 64'd0, ERR_UNTERM, 1);
      default: ;
    endcase
    mode = MODE_BETWEEN;
    u_want = 3'd0;
    u_held = 3'd0;
    add_event(KIND_EOF, 8'd0, 64'd0, ERR_NONE, pos_off, pos_line, pos_col, 32'd0);
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      mode <= MODE_BETWEEN;
      pos_off <= 32'd0; pos_line <= 24'd1; pos_col <= 16'd1;
      tok_off <= 32'd0; tok_line <= 24'd1; tok_col <= 16'd1;
      esc_off <= 32'd0; esc_line <= 24'd1; esc_col <= 16'd1;
      mag <= 64'd0; nflags <= 3'd0; kw <= 5'd0;
      u_want <= 3'd0; u_held <= 3'd0;
      fail_count <= 0;
      expected_events.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{kind: out_ch.kind, text_byte: out_ch.text_byte,
                number_value: out_ch.number_value, error_code: out_ch.error_code,
                start_offset: out_ch.start_offset, start_line: out_ch.start_line,
                start_column: out_ch.start_column, token_length: out_ch.token_length,
                last: out_ch.last};
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            $display("%0t: event mismatch, expected %p, actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        step_events.delete();
        if (in_ch.at_end) lex_end();
        else lex_byte(in_ch.in_byte);
        if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
        foreach (step_events[i]) expected_events.push_back(step_events[i]);
      end
    end
  end

endmodule

FILE: tb/sv/config_text_tokenizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_text_tokenizer_core_tb
// feeds source text and end marks through the tokenizer under random
// idling on both channels; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module config_text_tokenizer_core_tb;
  import ctt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   cycles = 0;

  // stimulus, one entry per transaction: bit 8 marks end of text
  logic [8:0] stim[$];
  int   sent = 0;
  bit   calm = 0;          // no idling in the last stretch
  bit   long_hold = 0;     // request for one long receiver hold-off

  ctt_in_if  in_ch();
  ctt_out_if out_ch();

  config_text_tokenizer_core dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  ctt_token_checker chk (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
                         .fail_count(fail_count), .pending(pending));

  always #5 clk = ~clk;

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[config_text_tokenizer_core] ERROR");
      $finish;
    end
  end

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) stim.push_back({1'b0, s[i]});
  endfunction

  function automatic void put_byte(logic [7:0] b);
    stim.push_back({1'b0, b});
  endfunction

  function automatic void put_end();
    stim.push_back(9'h100);
  endfunction

  // one random fragment of config text, mostly well formed
  function automatic void put_fragment();
    int n;
    case ($urandom_range(0, 11))
      0, 1: begin  // identifier, sometimes a keyword
        case ($urandom_range(0, 3))
          0: put_text("true");
          1: put_text("false");
          default: begin
            put_byte(8'("a" + $urandom_range(0, 25)));
            n = $urandom_range(0, 5);
            repeat (n)
              put_byte(8'($urandom_range(0, 3) == 0 ? "-" : "a" + $urandom_range(0, 25)));
          end
        endcase
      end
      2, 3: begin  // number, sometimes long enough to overflow
        if ($urandom_range(0, 2) == 0) put_byte("-");
        n = $urandom_range(0, 4) == 0 ? $urandom_range(17, 21) : $urandom_range(1, 5);
        repeat (n) put_byte(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0) put_byte(".");
      end
      4, 5: begin  // string with escapes and utf-8
        put_byte(8'h22);
        n = $urandom_range(0, 6);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: begin put_byte(8'h5c); put_byte($urandom_range(0, 7) == 0 ? "q" : "n"); end
            1: begin
              put_byte(8'(8'hc2 + $urandom_range(0, 29)));
              put_byte(8'(8'h80 + $urandom_range(0, 63)));
            end
            2: begin
              put_byte(8'he1);
              put_byte(8'(8'h80 + $urandom_range(0, 63)));
              put_byte(8'(8'h80 + $urandom_range(0, 63)));
            end
            3: begin
              put_byte(8'(8'hf0 + $urandom_range(0, 4)));
              put_byte(8'(8'h80 + $urandom_range(0, 63)));
              put_byte(8'(8'h80 + $urandom_range(0, 63)));
              put_byte(8'(8'h80 + $urandom_range(0, 63)));
            end
            4: put_byte(8'($urandom_range(0, 255)));
            default: put_byte(8'("a" + $urandom_range(0, 25)));
          endcase
        end
        if ($urandom_range(0, 7) != 0) put_byte(8'h22);
      end
      6: put_byte(8'($urandom_range(0, 255)));
      7: put_text("# note\n");
      8: put_byte($urandom_range(0, 1) ? "{" : "[");
      9: put_byte($urandom_range(0, 1) ? "}" : "]");
      10: if ($urandom_range(0, 5) == 0) put_end(); else put_byte(",");
      default: put_byte("=");
    endcase
    // separator between tokens
    case ($urandom_range(0, 4))
      0: put_byte(8'h0a);
      1: put_byte(";");
      2: put_byte(8'h09);
      default: put_byte(" ");
    endcase
  endfunction

  // receiver: random stall bursts plus one long hold-off
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold && hold == 0) begin
        hold = 300;
        long_hold = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 12) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int gap;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'd0;
    in_ch.at_end <= 1'b0;

    // directed text: keywords, signed extremes, number errors, escapes, utf-8
    put_text("k=true,false\n");
    put_text("-0;-;1.5 ");
    put_text("-9223372036854775808 9223372036854775808 ");
    put_byte(8'h22); put_byte(8'h5c); put_byte("t"); put_byte(8'hed); put_byte(8'h9f);
    put_byte(8'hbf); put_byte(8'hf4); put_byte(8'h90); put_byte(8'h80); put_byte(8'h80);
    put_text("@#x\n");
    put_byte(8'h22); put_byte(8'h5c); put_byte("x");
    put_byte(8'hff); put_byte(8'h00);
    put_byte(8'h22); put_byte(8'h5c); put_end();
    put_text("id"); put_end();
    while (stim.size() < 370) put_fragment();
    put_end();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (stim[i]) begin
      if (i == 150) long_hold = 1;
      if (i == stim.size() - 50) calm = 1;
      if (i == 260) begin
        // let everything drain before going on
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        gap = $urandom_range(1, 12);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.in_byte <= stim[i][7:0];
      in_ch.at_end <= stim[i][8];
      do @(posedge clk); while (!in_ch.ready);
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[config_text_tokenizer_core] OK");
    else
      $display("[config_text_tokenizer_core] ERROR");
    $finish;
  end

endmodule
